// File: src/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types, widths and constants of the retrain pattern detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

  localparam int SYM_W  = 16;  // received symbol word
  localparam int ACC_W  = 16;  // wrapping sums and the run
  localparam int CNT_W  = 15;  // symbol count, saturates at MAX_COUNT
  localparam int IQ_W   = 2;   // ideal quadrant
  localparam int THR_W  = 15;  // Q15 threshold
  localparam int RUN_W  = 15;  // minimum run
  localparam int MS_W   = 16;  // ms per symbol, Q14
  localparam int DUR_W  = 16;  // duration output
  localparam int CFG_DATA_W = 16;

  localparam int THR_SHIFT = 15;
  localparam int DUR_SHIFT = 14;

  localparam logic [CNT_W-1:0] MAX_COUNT = {CNT_W{1'b1}};

  localparam int QUAD_SHIFT_DEF = 2;
  localparam int QUAD_BITS_DEF  = 2;

  localparam logic [IQ_W-1:0]  IDEAL_QUAD_RST = 2'd3;
  localparam logic [THR_W-1:0] THRESH_RST     = 15'd16384;
  localparam logic [RUN_W-1:0] MIN_RUN_RST    = 15'd4;
  localparam logic [MS_W-1:0]  MS_PER_SYM_RST = 16'd27307;

  typedef enum logic [1:0] {
    CFG_IDEAL_QUAD = 2'd0,
    CFG_THRESH     = 2'd1,
    CFG_MIN_RUN    = 2'd2,
    CFG_MS_PER_SYM = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [IQ_W-1:0]  ideal_quadrant;
    logic [THR_W-1:0] match_threshold_q15;
    logic [RUN_W-1:0] min_run;
    logic [MS_W-1:0]  ms_per_symbol_q14;
  } cfg_t;

  // Block totals captured on the last symbol
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ACC_W-1:0] square_sum;
    logic [ACC_W-1:0] corr_sum;
    logic [ACC_W-1:0] energy;
    logic [ACC_W-1:0] run;
  } snap_t;

endpackage

`default_nettype wire

// File: src/rpd_if.sv
// ----------------------------------------------------------------------------
// rpd_if
// Valid/ready channels of the retrain pattern detector: symbols in,
// results out, and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpd_in_if;
  logic                     valid;
  logic                     ready;
  logic [rpd_pkg::SYM_W-1:0] symbol;
  logic                     last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface rpd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      detected;
  logic [rpd_pkg::DUR_W-1:0] duration_ms;

  modport source (output valid, output detected, output duration_ms, input ready);
  modport sink   (input valid, input detected, input duration_ms, output ready);
endinterface

interface rpd_cfg_if;
  logic                           valid;
  logic                           ready;
  rpd_pkg::cfg_idx_t              index;
  logic [rpd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/rpd_accum.sv
// ----------------------------------------------------------------------------
// rpd_accum
// Per-symbol accumulation: square sum, correlation, energy, period-two
// repetition run. Captures the block totals on the last symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_accum #(
  parameter int QUAD_SHIFT = rpd_pkg::QUAD_SHIFT_DEF,
  parameter int QUAD_BITS  = rpd_pkg::QUAD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rpd_pkg::SYM_W-1:0]   in_symbol,
  input  wire logic                        in_last_symbol,
  input  wire logic [rpd_pkg::IQ_W-1:0]    ideal_quadrant,
  input  wire logic                        snap_take,
  output logic                             snap_valid,
  output rpd_pkg::snap_t                   snap
);
  import rpd_pkg::*;

  localparam int QSQ_W = 2 * QUAD_BITS;
  localparam int QI_W  = QUAD_BITS + IQ_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ACC_W-1:0] sqsum_r, sqsum_nxt;
  logic [ACC_W-1:0] corr_r, corr_nxt;
  logic [ACC_W-1:0] energy_r, energy_nxt;
  logic [ACC_W-1:0] run_r, run_nxt;
  logic [SYM_W-1:0] recent_r [3];
  logic             snap_valid_r;
  snap_t            snap_r;

  logic             in_fire;
  logic             upd;
  logic [QUAD_BITS-1:0] q;
  logic [QSQ_W-1:0] q_sq;
  logic [QI_W-1:0]  q_ideal;
  logic [2*IQ_W-1:0] ideal_sq;
  logic             rep_match;

  assign in_ready = !snap_valid_r || snap_take;
  assign in_fire  = in_valid && in_ready;
  assign upd      = count_r != MAX_COUNT;

  assign q         = in_symbol[QUAD_SHIFT +: QUAD_BITS];
  assign q_sq      = QSQ_W'(q) * QSQ_W'(q);
  assign q_ideal   = QI_W'(q) * QI_W'(ideal_quadrant);
  assign ideal_sq  = (2*IQ_W)'(ideal_quadrant) * (2*IQ_W)'(ideal_quadrant);
  assign rep_match = (recent_r[0] == recent_r[2]) && (in_symbol == recent_r[1]);

  always_comb begin
    count_nxt  = count_r;
    sqsum_nxt  = sqsum_r;
    corr_nxt   = corr_r;
    energy_nxt = energy_r;
    run_nxt    = run_r;
    if (upd) begin
      count_nxt = count_r + 1'b1;
      sqsum_nxt = sqsum_r + ACC_W'(q_sq);
      if (!count_r[0]) begin
        corr_nxt   = corr_r + ACC_W'(q_ideal);
        energy_nxt = energy_r + ACC_W'(ideal_sq);
      end else if (count_r >= CNT_W'(3)) begin
        run_nxt = rep_match ? run_r + 1'b1 : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      sqsum_r      <= '0;
      corr_r       <= '0;
      energy_r     <= '0;
      run_r        <= '0;
      recent_r[0]  <= '0;
      recent_r[1]  <= '0;
      recent_r[2]  <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (in_fire && in_last_symbol) begin
        // close the block: totals go to the snapshot, state clears
        count_r      <= '0;
        sqsum_r      <= '0;
        corr_r       <= '0;
        energy_r     <= '0;
        run_r        <= '0;
        recent_r[0]  <= '0;
        recent_r[1]  <= '0;
        recent_r[2]  <= '0;
        snap_valid_r <= 1'b1;
      end else begin
        if (in_fire) begin
          count_r  <= count_nxt;
          sqsum_r  <= sqsum_nxt;
          corr_r   <= corr_nxt;
          energy_r <= energy_nxt;
          run_r    <= run_nxt;
          if (upd) begin
            recent_r[2] <= recent_r[1];
            recent_r[1] <= recent_r[0];
            recent_r[0] <= in_symbol;
          end
        end
        if (snap_take) begin
          snap_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_symbol) begin
      snap_r.count      <= count_nxt;
      snap_r.square_sum <= sqsum_nxt;
      snap_r.corr_sum   <= corr_nxt;
      snap_r.energy     <= energy_nxt;
      snap_r.run        <= run_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

`default_nettype wire

// File: src/rpd_decide.sv
// ----------------------------------------------------------------------------
// rpd_decide
// Detection decision and duration from the block totals, into the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_decide (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           snap_valid,
  input  rpd_pkg::snap_t      snap,
  input  rpd_pkg::cfg_t       cfg,
  output logic                snap_take,
  rpd_out_if.source           out_ch
);
  import rpd_pkg::*;

  localparam int PROD_W = 2 * ACC_W;
  localparam int DPROD_W = CNT_W + MS_W;

  logic              out_valid_r;
  logic              detected_r, detected_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;

  logic [ACC_W+1:0]  diff;
  logic [ACC_W+1:0]  mag;
  logic [ACC_W-1:0]  lhs;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  rhs;
  logic              corr_ok;
  logic              run_ok;
  logic [DPROD_W-1:0] dprod;

  assign snap_take = !out_valid_r || out_ch.ready;

  // |2*corr - sumsq|, both signed 16-bit
  assign diff = {snap.corr_sum[ACC_W-1], snap.corr_sum, 1'b0}
              - {{2{snap.square_sum[ACC_W-1]}}, snap.square_sum};
  assign mag  = diff[ACC_W+1] ? (~diff + 1'b1) : diff;
  assign lhs  = mag[ACC_W-1:0];

  // energy * threshold, scaled down rounding toward minus infinity
  assign prod   = PROD_W'($signed(snap.energy))
                * PROD_W'($signed({1'b0, cfg.match_threshold_q15}));
  assign prod_q = prod >>> THR_SHIFT;
  assign rhs    = prod_q[ACC_W-1:0];

  assign corr_ok = $signed(lhs) >= $signed(rhs);
  assign run_ok  = $signed(snap.run) > $signed({1'b0, cfg.min_run});

  assign dprod = DPROD_W'(snap.count) * DPROD_W'(cfg.ms_per_symbol_q14);

  always_comb begin
    detected_nxt = corr_ok && run_ok;
    dur_nxt      = detected_nxt ? dprod[DUR_SHIFT +: DUR_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_take) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && snap_valid) begin
      detected_r <= detected_nxt;
      dur_r      <= dur_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.detected    = detected_r;
  assign out_ch.duration_ms = dur_r;

endmodule

`default_nettype wire

// File: src/retrain_pattern_detector_core.sv
// ----------------------------------------------------------------------------
// retrain_pattern_detector_core
// Detects the period-two retrain pattern over a block of modem symbols and
// reports its duration when the block ends.
// ----------------------------------------------------------------------------
//  Channel   Dir   Payload                      Transfer
//  in_ch     in    symbol[15:0], last_symbol    valid & ready
//  out_ch    out   detected, duration_ms[15:0]  valid & ready, one per block
//  cfg_ch    in    index[1:0], data[15:0]       valid & ready, ready always 1
//
//  One symbol per cycle while in_ch is not stalled; sums update in the cycle
//  the transaction is taken. A block's result passes through the totals
//  snapshot, then through the decision logic into the result register.
//  in_ch stalls only when a finished block's totals wait behind a result
//  that out_ch has not taken. Reset (rst_n low, synchronous) clears all sums
//  and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module retrain_pattern_detector_core #(
  parameter int QUAD_SHIFT = rpd_pkg::QUAD_SHIFT_DEF,
  parameter int QUAD_BITS  = rpd_pkg::QUAD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rpd_in_if.sink     in_ch,
  rpd_out_if.source  out_ch,
  rpd_cfg_if.sink    cfg_ch
);
  import rpd_pkg::*;

  cfg_t  cfg_r;
  logic  snap_valid;
  snap_t snap;
  logic  snap_take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ideal_quadrant      <= IDEAL_QUAD_RST;
      cfg_r.match_threshold_q15 <= THRESH_RST;
      cfg_r.min_run             <= MIN_RUN_RST;
      cfg_r.ms_per_symbol_q14   <= MS_PER_SYM_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IDEAL_QUAD: cfg_r.ideal_quadrant      <= cfg_ch.data[IQ_W-1:0];
        CFG_THRESH:     cfg_r.match_threshold_q15 <= cfg_ch.data[THR_W-1:0];
        CFG_MIN_RUN:    cfg_r.min_run             <= cfg_ch.data[RUN_W-1:0];
        CFG_MS_PER_SYM: cfg_r.ms_per_symbol_q14   <= cfg_ch.data[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpd_accum #(
    .QUAD_SHIFT (QUAD_SHIFT),
    .QUAD_BITS  (QUAD_BITS)
  ) u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_symbol      (in_ch.symbol),
    .in_last_symbol (in_ch.last_symbol),
    .ideal_quadrant (cfg_r.ideal_quadrant),
    .snap_take      (snap_take),
    .snap_valid     (snap_valid),
    .snap           (snap)
  );

  rpd_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .cfg        (cfg_r),
    .snap_take  (snap_take),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
